[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the crossfade mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define BCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define BCM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/bcm_pkg.sv]
// Package of shared types and constants for the bypass crossfade mixer.
package bcm_pkg;

    // Default widths of samples and gains.
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_GAIN_BITS   = 16;

    // Fixed register widths.
    localparam int MIX_W  = 16;
    localparam int LEN_W  = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register reset values.
    localparam logic [MIX_W-1:0] MIX_RESET = 16'd32768;
    localparam logic [LEN_W-1:0] LEN_RESET = 16'd48;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MIX    = 2'd0;
    localparam logic [1:0] REG_LEN    = 2'd1;
    localparam logic [1:0] REG_START  = 2'd2;
    localparam logic [1:0] REG_MONO   = 2'd3;

    // Input commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_BYPASS = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_W,
        ST_MUL_L,
        ST_MUL_R,
        ST_UPD,
        ST_FIN
    } t_state;

endpackage

[sv/bypass_crossfade_mixer.sv]
// Top level of the dry/wet mixer with a linear bypass ramp.

// A sample transfer is answered by one result transfer after the steps accept, gain
// product, left product, right product with left rounding, right rounding with ramp
// update and output load; the next item is taken in the cycle after the result enters the
// output register. A set-bypass transfer gives no result; unless the level is already at
// its target, it occupies the block while the ramp step comes from a restoring divider that
// produces one quotient bit per cycle. All three products go through one shared signed
// multiplier under the sequencer. The output register lets a finished result wait while
// the block is idle; a further result waits in the last state until that register frees.
// Configuration writes are taken at any time; writing start_bypassed resets the ramp.
module bypass_crossfade_mixer
    import bcm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int GAIN_BITS   = DEF_GAIN_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic                          i_bypass_on,
    input  logic signed [SAMPLE_BITS-1:0] i_dry_left,
    input  logic signed [SAMPLE_BITS-1:0] i_dry_right,
    input  logic signed [SAMPLE_BITS-1:0] i_wet_left,
    input  logic signed [SAMPLE_BITS-1:0] i_wet_right,
    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    output logic                          o_ramping
);

    `include "assert_macros.svh"

    localparam int S   = SAMPLE_BITS;
    localparam int G   = GAIN_BITS;
    localparam int AW  = (S + 1 > G + 1) ? S + 1 : G + 1;
    localparam int PW  = AW + G + 1;
    localparam int MXW = (MIX_W > G + 1) ? MIX_W : G + 1;
    localparam int RW  = LEN_W + 1;
    localparam int CW  = $clog2(G);

    localparam logic [G-1:0]           UNITY    = {1'b1, {(G-1){1'b0}}};
    localparam logic [MXW-1:0]         UNITY_MX = {{(MXW-G){1'b0}}, UNITY};
    localparam logic signed [PW-1:0]   RND      = {{(PW-G+1){1'b0}}, 1'b1, {(G-2){1'b0}}};
    localparam logic signed [S+2:0]    SMAX     = {4'b0000, {(S-1){1'b1}}};
    localparam logic signed [S+2:0]    SMIN     = {4'b1111, {(S-1){1'b0}}};
    localparam logic [CW-1:0]          DIV_LAST = CW'(G - 1);

    // Saturate a widened sum to the sample range.
    function automatic logic signed [S-1:0] sat(input logic signed [S+2:0] v);
        logic signed [S-1:0] r;
        if (v > SMAX) begin
            r = SMAX[S-1:0];
        end else if (v < SMIN) begin
            r = SMIN[S-1:0];
        end else begin
            r = v[S-1:0];
        end
        return r;
    endfunction

    // Registers
    t_state                 r_state, n_state;
    logic [MIX_W-1:0]       r_mix;
    logic [LEN_W-1:0]       r_len;
    logic                   r_start_byp;
    logic                   r_mono;
    logic [G-1:0]           r_level;
    logic signed [G:0]      r_step;
    logic [LEN_W-1:0]       r_left;
    logic                   r_goal;
    logic [RW-1:0]          r_rem;
    logic [G-1:0]           r_quo;
    logic [CW-1:0]          r_cnt;
    logic signed [S-1:0]    r_dry_l, r_dry_r;
    logic signed [S:0]      r_dw_l, r_dw_r;
    logic [G-1:0]           r_w;
    logic signed [PW-1:0]   r_prod;
    logic signed [S-1:0]    r_res_l;
    logic signed [S-1:0]    r_res_r;
    logic                   r_out_valid;
    logic signed [S-1:0]    r_out_l, r_out_r;
    logic                   r_out_ramp;

    logic                   cfg_wr;
    logic [1:0]             cfg_idx;
    logic                   in_acc;
    logic                   out_free;
    logic                   in_stall;
    logic                   tgt_goal;
    logic [G-1:0]           tgt_level;
    logic [LEN_W-1:0]       len_eff;
    logic [MXW-1:0]         mix_ext;
    logic [G-1:0]           mix_c;
    logic signed [AW-1:0]   mul_a;
    logic signed [G:0]      mul_b;
    logic signed [PW-1:0]   mul_p;
    logic [RW-1:0]          rem_sh;
    logic                   rem_ge;
    logic signed [PW-1:0]   rnd_sum;
    logic signed [PW-1:0]   rnd_sh;
    logic signed [S+1:0]    sh_n;
    logic signed [S-1:0]    add_dry;
    logic signed [S+2:0]    mix_sum;
    logic signed [S-1:0]    mix_res;
    logic signed [G+1:0]    lvl_sum;
    logic [LEN_W-1:0]       left_dec;

    // Configuration access decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            REG_MIX:   prdata = DATA_W'(r_mix);
            REG_LEN:   prdata = DATA_W'(r_len);
            REG_START: prdata = DATA_W'(r_start_byp);
            REG_MONO:  prdata = DATA_W'(r_mono);
            default:   prdata = '0;
        endcase
    end

    // Handshake terms
    assign in_acc   = i_in_valid && !in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Ramp target and effective length
    assign tgt_goal  = !i_bypass_on;
    assign tgt_level = tgt_goal ? UNITY : '0;
    assign len_eff   = (r_len == '0) ? LEN_W'(1) : r_len;

    // Mix amount clamped to unity
    assign mix_ext = MXW'(r_mix);
    assign mix_c   = (mix_ext > UNITY_MX) ? UNITY : mix_ext[G-1:0];

    // Shared multiplier operand selection
    always_comb begin
        case (r_state)
            ST_MUL_W: begin
                mul_a = AW'(r_level);
                mul_b = (G+1)'(mix_c);
            end
            ST_MUL_R: begin
                mul_a = AW'(r_dw_r);
                mul_b = (G+1)'(r_w);
            end
            default: begin
                mul_a = AW'(r_dw_l);
                mul_b = (G+1)'(r_w);
            end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Divider step: one quotient bit per cycle
    assign rem_sh = {r_rem[RW-2:0], r_quo[G-1]};
    assign rem_ge = rem_sh >= RW'(len_eff);

    // Rounding, dry add and saturation of the registered product
    assign rnd_sum = r_prod + RND;
    assign rnd_sh  = rnd_sum >>> (G - 1);
    assign sh_n    = rnd_sh[S+1:0];
    assign add_dry = (r_state == ST_UPD) ? r_dry_r : r_dry_l;
    assign mix_sum = (S+3)'(add_dry) + (S+3)'(sh_n);
    assign mix_res = sat(mix_sum);

    // Ramp advance
    assign lvl_sum  = (G+2)'(signed'({1'b0, r_level})) + (G+2)'(r_step);
    assign left_dec = r_left - LEN_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_SAMPLE) begin
                        n_state = ST_MUL_W;
                    end else if (r_level != tgt_level) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL_W: n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_UPD;
            ST_UPD:   n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        case (r_state)
            ST_IDLE: in_stall = 1'b0;
            default: in_stall = 1'b1;
        endcase
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_ramping   = r_out_ramp;

    // Control state, configuration and ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mix       <= MIX_RESET;
            r_len       <= LEN_RESET;
            r_start_byp <= 1'b0;
            r_mono      <= 1'b0;
            r_level     <= UNITY;
            r_goal      <= 1'b1;
            r_step      <= '0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Output register fills from the last state and empties on a result transfer
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Writing start_bypassed reinitialises the ramp; otherwise the sequencer runs it
            if (cfg_wr && cfg_idx == REG_START) begin
                r_start_byp <= pwdata[0];
                r_level     <= pwdata[0] ? '0 : UNITY;
                r_goal      <= !pwdata[0];
                r_step      <= '0;
                r_left      <= '0;
            end else begin
                case (r_state)
                    ST_IDLE: begin
                        if (in_acc && i_command == CMD_BYPASS) begin
                            r_goal <= tgt_goal;
                            if (r_level == tgt_level) begin
                                r_left <= '0;
                                r_step <= '0;
                            end else begin
                                r_left <= len_eff;
                                r_cnt  <= DIV_LAST;
                            end
                        end
                    end
                    ST_DIV: begin
                        r_cnt <= r_cnt - CW'(1);
                        if (r_cnt == '0) begin
                            // Quotient complete: apply the direction of the ramp
                            if (r_goal) begin
                                r_step <= signed'({1'b0, r_quo[G-2:0], rem_ge});
                            end else begin
                                r_step <= -signed'({1'b0, r_quo[G-2:0], rem_ge});
                            end
                        end
                    end
                    ST_UPD: begin
                        if (r_left != '0) begin
                            r_left <= left_dec;
                            if (left_dec == '0) begin
                                r_level <= r_goal ? UNITY : '0;
                            end else begin
                                r_level <= lvl_sum[G-1:0];
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Remaining configuration writes
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_MIX:   r_mix  <= pwdata[MIX_W-1:0];
                    REG_LEN:   r_len  <= pwdata[LEN_W-1:0];
                    REG_MONO:  r_mono <= pwdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_command == CMD_BYPASS) begin
                    r_rem <= '0;
                    r_quo <= tgt_goal ? (UNITY - r_level) : r_level;
                end
                if (in_acc && i_command == CMD_SAMPLE) begin
                    r_dry_l <= i_dry_left;
                    r_dry_r <= i_dry_right;
                    r_dw_l  <= (S+1)'(i_wet_left) - (S+1)'(i_dry_left);
                    r_dw_r  <= (r_mono ? (S+1)'(i_wet_left) : (S+1)'(i_wet_right))
                               - (S+1)'(i_dry_right);
                end
            end
            ST_DIV: begin
                r_rem <= rem_ge ? (rem_sh - RW'(len_eff)) : rem_sh;
                r_quo <= {r_quo[G-2:0], rem_ge};
            end
            ST_MUL_W: r_w <= mul_p[2*G-2:G-1];
            ST_MUL_L: r_prod <= mul_p;
            ST_MUL_R: begin
                r_res_l <= mix_res;
                r_prod  <= mul_p;
            end
            ST_FIN: begin
                if (out_free) begin
                    r_out_l    <= r_res_l;
                    r_out_r    <= r_res_r;
                    r_out_ramp <= (r_left != '0);
                end
            end
            default: begin
            end
        endcase
    end

    // ST_UPD forms the right result; hold it until the output register frees
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_res_r <= mix_res;
        end
    end

    // Assertions
    `BCM_ASSERT(a_level_range, (r_level <= UNITY), "fade level above unity")
    `BCM_ASSERT(a_level_snapped,
        ((r_left == '0) |-> (r_level == '0 || r_level == UNITY)),
        "idle ramp with a level between the end points")
    `BCM_ASSERT(a_result_loaded,
        ((r_state == ST_FIN && out_free) |=> (r_out_valid && r_state == ST_IDLE)),
        "finished sample not loaded into the output register")

endmodule

[tb/sv/tb_bypass_crossfade_mixer.sv]
// Self-checking testbench for the bypass crossfade mixer: stimulus, prediction and checks.
module tb_bypass_crossfade_mixer
    import bcm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int       SW         = DEF_SAMPLE_BITS;
    localparam int       GW         = DEF_GAIN_BITS;
    localparam longint   UNITY      = longint'(1) << (GW - 1);
    localparam int       HALF_CLK   = 5;
    localparam int       SETTLE_CYC = 2 * (GW + 1) + 6;
    localparam int       DRAIN_MAX  = 20000;
    localparam int       HOLD_CYC   = 300;

    typedef struct {
        logic                 cmd;
        logic                 byp;
        logic signed [SW-1:0] dl;
        logic signed [SW-1:0] dr;
        logic signed [SW-1:0] wl;
        logic signed [SW-1:0] wr;
    } t_mix_item;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 ramping;
    } t_mix_result;

    // Clock, reset and every block input start at known values.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [DATA_W-1:0]    pwdata      = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [SW-1:0] o_out_left;
    logic signed [SW-1:0] o_out_right;
    logic                 o_ramping;

    t_mix_item   cur_item = '{cmd: CMD_SAMPLE, byp: 1'b0, dl: '0, dr: '0, wl: '0, wr: '0};
    t_mix_item   sample_feed_q[$];
    t_mix_result mix_due_q[$];

    // Mirror of the registers and of the ramp state.
    logic [15:0] cfg_mix       = MIX_RESET;
    logic [15:0] cfg_len       = LEN_RESET;
    logic        cfg_start_byp = 1'b0;
    logic        cfg_mono      = 1'b0;
    longint      fade_lvl      = UNITY;
    longint      fade_inc      = 0;
    longint      fade_remain   = 0;
    logic        fade_goal     = 1'b1;

    // Run bookkeeping.
    logic in_taken      = 1'b0;
    logic hold_out      = 1'b0;
    int   taken_count   = 0;
    int   sample_count  = 0;
    int   toggle_count  = 0;
    int   checked_count = 0;
    int   backed_up     = 0;
    int   setting_count = 0;
    int   err_count     = 0;

    logic                 i_command;
    logic                 i_bypass_on;
    logic signed [SW-1:0] i_dry_left;
    logic signed [SW-1:0] i_dry_right;
    logic signed [SW-1:0] i_wet_left;
    logic signed [SW-1:0] i_wet_right;

    assign i_command   = cur_item.cmd;
    assign i_bypass_on = cur_item.byp;
    assign i_dry_left  = cur_item.dl;
    assign i_dry_right = cur_item.dr;
    assign i_wet_left  = cur_item.wl;
    assign i_wet_right = cur_item.wr;

    bypass_crossfade_mixer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_bypass_on (i_bypass_on),
        .i_dry_left  (i_dry_left),
        .i_dry_right (i_dry_right),
        .i_wet_left  (i_wet_left),
        .i_wet_right (i_wet_right),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_left  (o_out_left),
        .o_out_right (o_out_right),
        .o_ramping   (o_ramping)
    );

    // Free-running clock.
    always #(HALF_CLK) i_clk = ~i_clk;

    // Prints one mismatch and counts it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("[%0t] mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Puts the ramp back to its starting point, as reset and start_bypassed writes do.
    function automatic void restart_fade();
        fade_lvl    = cfg_start_byp ? 0 : UNITY;
        fade_goal   = !cfg_start_byp;
        fade_inc    = 0;
        fade_remain = 0;
    endfunction

    // One channel: dry + (wet - dry) * w, rounded half up, then saturated.
    function automatic logic signed [SW-1:0] blend_channel(input longint dry, input longint wet,
                                                           input longint w);
        longint prod;
        longint sum;
        longint top;
        top  = (longint'(1) << (SW - 1)) - 1;
        prod = (wet - dry) * w + (longint'(1) << (GW - 2));
        sum  = dry + (prod >>> (GW - 1));
        if (sum > top) begin
            sum = top;
        end
        if (sum < -top - 1) begin
            sum = -top - 1;
        end
        return sum[SW-1:0];
    endfunction

    // Advances the mixer state by one transfer; returns 1 with the mixed sample when one is due.
    function automatic logic mix_and_ramp(input t_mix_item it, output t_mix_result res);
        longint target;
        longint span;
        longint mix;
        longint w;
        longint wet_r;
        res = '{left: '0, right: '0, ramping: 1'b0};
        if (it.cmd == CMD_BYPASS) begin
            target    = it.byp ? 0 : UNITY;
            fade_goal = !it.byp;
            if (fade_lvl == target) begin
                fade_remain = 0;
                fade_inc    = 0;
            end else begin
                span        = (cfg_len == 0) ? 1 : longint'(cfg_len);
                fade_remain = span;
                fade_inc    = (target - fade_lvl) / span;
            end
            return 1'b0;
        end
        mix       = (longint'(cfg_mix) > UNITY) ? UNITY : longint'(cfg_mix);
        w         = (fade_lvl * mix) >>> (GW - 1);
        wet_r     = cfg_mono ? longint'(it.wl) : longint'(it.wr);
        res.left  = blend_channel(it.dl, it.wl, w);
        res.right = blend_channel(it.dr, wet_r, w);
        if (fade_remain > 0) begin
            fade_lvl    = fade_lvl + fade_inc;
            fade_remain = fade_remain - 1;
            if (fade_remain == 0) begin
                fade_lvl = fade_goal ? UNITY : 0;
            end
        end
        res.ramping = (fade_remain != 0);
        return 1'b1;
    endfunction

    // Idle shares of the two sides, switched as the run goes on.
    function automatic int sender_idle_pct();
        if (taken_count < 380) begin
            return 14;
        end
        return (taken_count < 760) ? 49 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (taken_count < 380) begin
            return 49;
        end
        return (taken_count < 760) ? 14 : 0;
    endfunction

    // Sample values weighted towards the extremes.
    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                return {1'b0, {(SW-1){1'b1}}};
            end
            1: begin
                return {1'b1, {(SW-1){1'b0}}};
            end
            2: begin
                return '0;
            end
            3: begin
                return SW'($urandom_range(0, 511) - 256);
            end
            default: begin
                return SW'($urandom);
            end
        endcase
    endfunction

    task automatic push_sample(input logic signed [SW-1:0] dl, input logic signed [SW-1:0] dr,
                               input logic signed [SW-1:0] wl, input logic signed [SW-1:0] wr,
                               input logic byp);
        t_mix_item it;
        it = '{cmd: CMD_SAMPLE, byp: byp, dl: dl, dr: dr, wl: wl, wr: wr};
        sample_feed_q.insert(sample_feed_q.size(), it);
    endtask

    // A set-bypass transfer carries random sample fields, which the block ignores.
    task automatic push_toggle(input logic byp);
        t_mix_item it;
        it = '{cmd: CMD_BYPASS, byp: byp, dl: pick_sample(),
               dr: pick_sample(), wl: pick_sample(), wr: pick_sample()};
        sample_feed_q.insert(sample_feed_q.size(), it);
    endtask

    // Register write over the configuration port, mirrored once the write lands.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MIX: begin
                cfg_mix = val[15:0];
            end
            REG_LEN: begin
                cfg_len = val[15:0];
            end
            REG_START: begin
                cfg_start_byp = val[0];
                restart_fade();
            end
            REG_MONO: begin
                cfg_mono = val[0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits until every queued item has gone in and every result has come out.
    task automatic drain();
        int waited;
        waited = 0;
        while (sample_feed_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (mix_due_q.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mix_due_q.size() != 0) begin
            report_mismatch("results never delivered", 0, mix_due_q.size());
            mix_due_q.delete();
        end
    endtask

    // One setting of all four registers, followed by a stretch of random traffic.
    task automatic run_setting(input logic [15:0] mix, input logic [15:0] len,
                               input logic start_byp, input logic mono, input int n);
        write_reg(REG_MIX, DATA_W'(mix));
        write_reg(REG_LEN, DATA_W'(len));
        write_reg(REG_MONO, DATA_W'(mono));
        write_reg(REG_START, DATA_W'(start_byp));
        setting_count++;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                push_toggle(1'($urandom_range(0, 1)));
            end else begin
                push_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                            1'($urandom_range(0, 1)));
            end
        end
        drain();
    endtask

    // Input driver: holds a stalled transfer, otherwise offers the next item or idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !in_taken)) begin
            if (sample_feed_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                cur_item   <= sample_feed_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // Output side stall, random or held off for a long stretch.
    always @(negedge i_clk) begin
        i_out_stall <= hold_out || ($urandom_range(0, 99) < receiver_idle_pct());
    end

    // Monitor: predicts on each input transfer and checks each result transfer.
    always @(posedge i_clk) begin
        t_mix_result res;
        t_mix_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                taken_count++;
                if (cur_item.cmd == CMD_BYPASS) begin
                    toggle_count++;
                end else begin
                    sample_count++;
                end
                if (mix_and_ramp(cur_item, res)) begin
                    mix_due_q.insert(mix_due_q.size(), res);
                end
            end
            if (hold_out && i_in_valid && o_in_stall) begin
                backed_up++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (mix_due_q.size() == 0) begin
                    report_mismatch("result with nothing pending", o_out_left, 0);
                end else begin
                    want = mix_due_q.pop_front();
                    checked_count++;
                    if (o_out_left !== want.left) begin
                        report_mismatch("out_left", o_out_left, want.left);
                    end
                    if (o_out_right !== want.right) begin
                        report_mismatch("out_right", o_out_right, want.right);
                    end
                    if (o_ramping !== want.ramping) begin
                        report_mismatch("ramping", o_ramping, want.ramping);
                    end
                end
            end
        end
    end

    // Long receiver hold-off so that the block backs up into its input.
    initial begin
        wait (taken_count >= 200);
        @(posedge i_clk);
        hold_out = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_out = 1'b0;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Main sequence: reset, directed checks, then random traffic over several settings.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: full scale extremes, zeros, a stray bypass flag on a sample.
        push_sample({1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}},
                    {1'b1, {(SW-1){1'b0}}}, {1'b0, {(SW-1){1'b1}}}, 1'b0);
        push_sample('0, '0, '0, '0, 1'b1);
        push_sample(SW'(-1), SW'(1), SW'(1), SW'(-1), 1'b0);
        // Toggle to the level already reached, then a ramp interrupted after two samples.
        push_toggle(1'b0);
        push_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample(), 1'b0);
        push_toggle(1'b1);
        push_sample({1'b0, {(SW-1){1'b1}}}, '0, {1'b1, {(SW-1){1'b0}}}, '0, 1'b0);
        push_sample(SW'(12345), SW'(-12345), SW'(-8000000), SW'(8000000), 1'b0);
        push_toggle(1'b0);
        push_sample(SW'(100), SW'(-100), SW'(300), SW'(-300), 1'b0);
        push_sample(SW'(-1), SW'(-1), '0, '0, 1'b0);
        drain();

        // Short ramps run to the end and snap; toggles at both end levels.
        write_reg(REG_LEN, DATA_W'(2));
        write_reg(REG_START, DATA_W'(0));
        push_toggle(1'b1);
        for (int k = 0; k < 3; k++) begin
            push_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample(), 1'b0);
        end
        push_toggle(1'b1);
        push_sample({1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}}, '0, '0, 1'b0);
        push_toggle(1'b0);
        for (int k = 0; k < 3; k++) begin
            push_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample(), 1'b1);
        end
        drain();

        // Random traffic; the settings cover both ends of each register.
        run_setting(16'd32768, 16'd48, 1'b0, 1'b0, 160);
        run_setting(16'd16384, 16'd1, 1'b0, 1'b1, 160);
        run_setting(16'd0, 16'd0, 1'b1, 1'b0, 160);
        run_setting(16'd65535, 16'd5, 1'b0, 1'b0, 160);
        run_setting(16'($urandom_range(0, 40000)), 16'd3, 1'b1, 1'b1, 160);
        run_setting(16'd32768, 16'd65535, 1'b0, 1'b0, 160);
        run_setting(16'd20000, 16'd7, 1'b0, 1'b1, 160);

        $display("tb: %0d samples and %0d bypass toggles sent over %0d register settings,",
                 sample_count, toggle_count, setting_count + 1);
        $display("tb: %0d results checked, input held back for %0d cycles under hold-off",
                 checked_count, backed_up);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/bcm_pkg.sv
sv/bypass_crossfade_mixer.sv
tb/sv/tb_bypass_crossfade_mixer.sv
